// File: hdl/fgdd_pkg.sv
package fgdd_pkg;

	localparam int CH_W = 8;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_PASS  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [6:0]      col;
		logic [5:0]      row;
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} cmd_t;

	typedef struct packed {
		logic [1:0]      done_kind;
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
	} rsp_t;

	localparam logic [CH_W-1:0] DECAY_RESET = 8'd4;

endpackage

// File: hdl/fire_grid_diffuse_decay.sv
// Fire glow grid with diffusion and decay.
// cmd channel (cmd_valid / cmd_stall, payload cmd): one item per command.
//   kind write loads one cell, kind read fetches one cell, kind pass runs one
//   in-place diffusion pass over the whole grid, row by row, left to right.
// rsp channel (rsp_valid / rsp_stall, payload rsp): exactly one item per
//   command, carrying the kind and, for a read, the cell's channels.
// cfg channel (cfg_valid / cfg_ready, cfg_data): decay amount, reset value 4.
//   cfg_ready is always high; write it only while the block is idle.
// Timing: the grid sits in one single-port RAM (one access per cycle, read
//   data registered). A write passes through ST_EXEC and ST_RESP after
//   acceptance, a read through ST_EXEC, ST_RDWAIT and ST_RESP. A pass works
//   through each cell in steps: nine neighbourhood reads through the port,
//   a drain of the read register (ST_DRAIN), then a write-back (ST_WRITE).
//   One command at a time: cmd_stall stays high until the command's response is in the output register.
// Reset: the RAM is swept to zero, one cell per cycle, with cmd_stall high;
//   cfg writes are taken throughout.
// A stalled response holds in the output register; the next command is
//   accepted meanwhile, and its own response waits until the register frees.
module fire_grid_diffuse_decay #(
	parameter int GRID_COLS = 128,
	parameter int GRID_ROWS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  fgdd_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fgdd_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_data
);
	import fgdd_pkg::*;

	localparam int CELLS = GRID_COLS * GRID_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(GRID_COLS);
	localparam int RW    = $clog2(GRID_ROWS);
	localparam logic [AW-1:0] COLS_A    = AW'(GRID_COLS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [CW-1:0] LAST_COL  = CW'(GRID_COLS - 1);
	localparam logic [RW-1:0] LAST_ROW  = RW'(GRID_ROWS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_EXEC, ST_RDWAIT, ST_TAP, ST_DRAIN, ST_WRITE, ST_RESP
	} state_t;

	state_t          state_q;
	cmd_t            item_q;
	rsp_t            res_q;
	rsp_t            rsp_q;
	logic            rsp_valid_q;
	logic [7:0]      decay_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   base_q;
	logic [CW-1:0]   c_q;
	logic [RW-1:0]   r_q;
	logic [3:0]      tap_q;
	logic            acc_vld_s1;
	logic            use_s1;
	logic            ctr_s1;
	logic [8:0]      acc_r_q, acc_g_q, acc_b_q;
	logic [23:0]     rd_s1;

	logic [23:0]     mem [CELLS];
	logic            mem_we;
	logic [AW-1:0]   mem_addr;
	logic [23:0]     mem_wdata;

	logic            in_grid;
	logic [AW-1:0]   rw_addr;
	logic [AW-1:0]   tap_addr;
	logic            tap_ok;
	logic            top_ok, bot_ok, lft_ok, rgt_ok;
	logic [8:0]      add_r, add_g, add_b;
	logic [7:0]      new_r, new_g, new_b;

	function automatic logic [8:0] contrib(input logic [7:0] v, input logic centre);
		contrib = centre ? {1'b0, v} : {4'd0, v[7:3]};
	endfunction

	function automatic logic [7:0] settle(input logic [8:0] sum, input logic [7:0] decay);
		logic [7:0] half;
		half   = sum[8:1];
		settle = (half > decay) ? half - decay : 8'd0;
	endfunction

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	assign in_grid = (32'(item_q.col) < GRID_COLS) && (32'(item_q.row) < GRID_ROWS);
	assign rw_addr = AW'(item_q.row) * COLS_A + AW'(item_q.col);

	assign top_ok = (r_q != '0);
	assign bot_ok = (r_q != LAST_ROW);
	assign lft_ok = (c_q != '0);
	assign rgt_ok = (c_q != LAST_COL);

	// neighbourhood taps in raster order, centre is tap 4
	always_comb begin
		tap_addr = base_q;
		tap_ok   = 1'b1;
		unique case (tap_q)
			4'd0: begin
				tap_addr = base_q - COLS_A - AW'(1);
				tap_ok   = top_ok && lft_ok;
			end
			4'd1: begin
				tap_addr = base_q - COLS_A;
				tap_ok   = top_ok;
			end
			4'd2: begin
				tap_addr = base_q - COLS_A + AW'(1);
				tap_ok   = top_ok && rgt_ok;
			end
			4'd3: begin
				tap_addr = base_q - AW'(1);
				tap_ok   = lft_ok;
			end
			4'd4: begin
				tap_addr = base_q;
				tap_ok   = 1'b1;
			end
			4'd5: begin
				tap_addr = base_q + AW'(1);
				tap_ok   = rgt_ok;
			end
			4'd6: begin
				tap_addr = base_q + COLS_A - AW'(1);
				tap_ok   = bot_ok && lft_ok;
			end
			4'd7: begin
				tap_addr = base_q + COLS_A;
				tap_ok   = bot_ok;
			end
			4'd8: begin
				tap_addr = base_q + COLS_A + AW'(1);
				tap_ok   = bot_ok && rgt_ok;
			end
			default: begin
				tap_addr = base_q;
				tap_ok   = 1'b0;
			end
		endcase
	end

	always_comb begin
		add_r = '0;
		add_g = '0;
		add_b = '0;
		if (acc_vld_s1 && use_s1) begin
			add_r = contrib(rd_s1[23:16], ctr_s1);
			add_g = contrib(rd_s1[15:8], ctr_s1);
			add_b = contrib(rd_s1[7:0], ctr_s1);
		end
	end

	assign new_r = settle(acc_r_q, decay_q);
	assign new_g = settle(acc_g_q, decay_q);
	assign new_b = settle(acc_b_q, decay_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = base_q;
		mem_wdata = {new_r, new_g, new_b};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			ST_EXEC: begin
				mem_we    = (item_q.kind == KIND_WRITE) && in_grid;
				mem_addr  = rw_addr;
				mem_wdata = {item_q.in_red, item_q.in_green, item_q.in_blue};
			end
			ST_TAP: mem_addr = tap_addr;
			ST_WRITE: mem_we = 1'b1;
			default: mem_we = 1'b0;
		endcase
	end

	// single-port grid RAM, read data registered
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rd_s1 <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			item_q      <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			decay_q     <= DECAY_RESET;
			clr_q       <= '0;
			base_q      <= '0;
			c_q         <= '0;
			r_q         <= '0;
			tap_q       <= '0;
			acc_vld_s1  <= 1'b0;
			use_s1      <= 1'b0;
			ctr_s1      <= 1'b0;
			acc_r_q     <= '0;
			acc_g_q     <= '0;
			acc_b_q     <= '0;
		end else begin
			if (cfg_valid)
				decay_q <= cfg_data;
			if (state_q == ST_RESP && (!rsp_valid_q || !rsp_stall))
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;

			// accumulator restarts at the start of a pass and after each write-back
			acc_vld_s1 <= (state_q == ST_TAP);
			if (state_q == ST_EXEC || state_q == ST_WRITE) begin
				acc_r_q <= '0;
				acc_g_q <= '0;
				acc_b_q <= '0;
			end else begin
				acc_r_q <= acc_r_q + add_r;
				acc_g_q <= acc_g_q + add_g;
				acc_b_q <= acc_b_q + add_b;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_CELL)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						item_q  <= cmd;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_q <= '{done_kind: item_q.kind, default: '0};
					priority if (item_q.kind == KIND_READ && in_grid) begin
						state_q <= ST_RDWAIT;
					end else if (item_q.kind == KIND_PASS) begin
						base_q  <= '0;
						c_q     <= '0;
						r_q     <= '0;
						tap_q   <= '0;
						state_q <= ST_TAP;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RDWAIT: begin
					res_q.out_red   <= rd_s1[23:16];
					res_q.out_green <= rd_s1[15:8];
					res_q.out_blue  <= rd_s1[7:0];
					state_q         <= ST_RESP;
				end
				ST_TAP: begin
					use_s1     <= tap_ok;
					ctr_s1     <= (tap_q == 4'd4);
					tap_q      <= tap_q + 4'd1;
					if (tap_q == 4'd8)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_WRITE;
				ST_WRITE: begin
					tap_q   <= '0;
					base_q  <= base_q + AW'(1);
					if (c_q == LAST_COL) begin
						c_q <= '0;
						r_q <= r_q + RW'(1);
					end else begin
						c_q <= c_q + CW'(1);
					end
					state_q <= (c_q == LAST_COL && r_q == LAST_ROW) ? ST_RESP : ST_TAP;
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_rsp_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !rsp_valid_q)
		else $error("response raised during RAM sweep");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TAP |-> tap_q <= 4'd8)
		else $error("tap counter out of range");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> acc_r_q <= 9'd503 && acc_g_q <= 9'd503 && acc_b_q <= 9'd503)
		else $error("neighbourhood sum exceeds its bound");

	a_base_tracks_cell: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TAP |-> base_q == AW'(32'(r_q) * GRID_COLS + 32'(c_q)))
		else $error("cell address out of step with row and column");

	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second item taken while one is in flight");

	a_rsp_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> rsp_valid_q && $stable(rsp_q))
		else $error("stalled response dropped or changed");

endmodule
